FILE: sv/sti_pkg.sv
// Package for the sorted table insert/delete unit: sizes, codes and the
// structs passed between the top level and the row of storage cells.
// No dependencies.
package sti_pkg;

    localparam int CAPACITY    = 64;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_CNT_W   = 7;
    localparam int OUT_TDATA_W = 16;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_FIND   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_ABSENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } state_t;

    // Broadcast to every cell.
    typedef struct packed {
        logic   cmp_en;
        logic   ins_en;
        logic   del_en;
        value_t value;
    } cell_cmd_t;

    // What a cell shows its neighbours.
    typedef struct packed {
        logic   valid;
        logic   lt;
        value_t entry;
    } cell_link_t;

endpackage

FILE: sv/sorted_table_insert_delete_unit.sv
// Top level of the sorted table insert/delete unit: control sequencer,
// result register and the row of sti_cell storage cells.
// Depends on sti_pkg and sti_cell.
//
// Usage
//   Input channel s_*: one beat per operation. s_tuser carries the kind
//   (insert, delete one occurrence, find; the unused code acts as find),
//   s_tdata the signed 32-bit operand.
//   Output channel m_*: one beat per operation, in order: status, the
//   found flag (value present before the operation) and the entry count
//   after it, modulo 128.
//   The table is a row of CAPACITY cells kept in ascending order. Every
//   cell compares its entry with the operand in parallel; on an insert or
//   delete each cell then loads from itself, its left or right neighbour,
//   or the operand, so the whole table shifts in the same cycle.
//   Each operation passes through the accept, compare and update steps in
//   turn, and the next is accepted only after the update step; the compare
//   result is registered in the cells and reduced in the update step.
//   While a result waits for m_tready the next operation is accepted and
//   compared; it holds in its update step until the result register frees.
//   Reset empties the table (cell valid bits and count cleared); no
//   clearing pass is needed.
module sorted_table_insert_delete_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [2] found, [9:3] entry_count
);
    import sti_pkg::*;

    state_t state_reg, state_next;

    logic [KIND_W-1:0] kind_reg, kind_next;
    value_t            value_reg, value_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_found_reg, out_found_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;

    cell_cmd_t  cmd;
    cell_link_t links [CAPACITY];
    cell_link_t left_in [CAPACITY];
    cell_link_t right_in [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] valid_vec;

    logic upd_go;
    logic present;
    logic full;

    assign present = |eq_vec;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign upd_go  = (state_reg == ST_UPDATE) && (!out_valid_reg || m_tready);

    // Row of cells; the first cell sees a left neighbour that is always
    // below the operand, the last one an empty right neighbour.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_in[i] = '{valid: 1'b1, lt: 1'b1, entry: '0};
        end
        else
        begin : g_mid_left
            assign left_in[i] = links[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in[i] = '{valid: 1'b0, lt: 1'b0, entry: '0};
        end
        else
        begin : g_mid_right
            assign right_in[i] = links[i+1];
        end

        sti_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_in[i]),
            .right (right_in[i]),
            .self  (links[i]),
            .eq    (eq_vec[i])
        );
        assign valid_vec[i] = links[i].valid;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_COMPARE;
            end
            ST_COMPARE:
                state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (upd_go)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and cell commands
    always_comb
    begin
        s_tready   = 1'b0;
        cmd.cmp_en = 1'b0;
        cmd.ins_en = 1'b0;
        cmd.del_en = 1'b0;
        cmd.value  = value_reg;
        case (state_reg)
            ST_IDLE:
                s_tready = 1'b1;
            ST_COMPARE:
                cmd.cmp_en = 1'b1;
            ST_UPDATE:
            begin
                cmd.ins_en = upd_go && (kind_reg == KIND_INSERT) && !full;
                cmd.del_en = upd_go && (kind_reg == KIND_DELETE) && present;
            end
            default:
                s_tready = 1'b0;
        endcase
    end

    // Operand capture, count and result register
    always_comb
    begin
        kind_next       = kind_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;

        if (s_tvalid && s_tready)
        begin
            kind_next  = s_tuser;
            value_next = s_tdata;
        end

        if (m_tready)
            out_valid_next = 1'b0;

        if (upd_go)
        begin
            out_status_next = STATUS_DONE;
            case (kind_reg)
                KIND_INSERT:
                begin
                    if (full)
                        out_status_next = STATUS_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                KIND_DELETE:
                begin
                    if (present)
                        count_next = count_reg - CNT_W'(1);
                    else
                        out_status_next = STATUS_ABSENT;
                end
                default:
                begin
                    if (!present)
                        out_status_next = STATUS_ABSENT;
                end
            endcase
            out_valid_next = 1'b1;
            out_found_next = present;
            out_count_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, OUT_CNT_W'(out_count_reg), out_found_reg, out_status_reg};

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("occupied cells disagree with entry count");

    a_compare_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPARE) |=> (state_reg == ST_UPDATE))
        else $error("compare step not followed by update step");

    a_result_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |=> m_tvalid)
        else $error("update step produced no result");

endmodule

FILE: sv/sti_cell.sv
// One storage cell of the sorted table: holds an entry, compares it with
// the broadcast operand and shifts with its neighbours on insert/delete.
// Depends on sti_pkg.
module sti_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sti_pkg::cell_cmd_t cmd,
    input  sti_pkg::cell_link_t left,
    input  sti_pkg::cell_link_t right,
    output sti_pkg::cell_link_t self,
    output logic               eq
);
    import sti_pkg::*;

    logic   valid_reg, valid_next;
    logic   lt_reg, lt_next;
    logic   eq_reg, eq_next;
    value_t entry_reg, entry_next;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (cmd.cmp_en)
        begin
            lt_next = valid_reg && (entry_reg < cmd.value);
            eq_next = valid_reg && (entry_reg == cmd.value);
        end
        if (cmd.ins_en && !lt_reg)
        begin
            // first cell not below the operand takes it, the rest move up
            if (left.lt)
            begin
                entry_next = cmd.value;
                valid_next = 1'b1;
            end
            else
            begin
                entry_next = left.entry;
                valid_next = left.valid;
            end
        end
        if (cmd.del_en && !lt_reg)
        begin
            entry_next = right.entry;
            valid_next = right.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign self.valid = valid_reg;
    assign self.lt    = lt_reg;
    assign self.entry = entry_reg;
    assign eq         = eq_reg;

endmodule

FILE: verif/sti_result_checker.sv
// Result checker for the sorted table insert/delete unit: watches both stream
// channels, predicts each result beat and compares it field by field.
// Depends on sti_pkg.
module sti_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [1:0] status, [2] found, [9:3] entry_count
    output int          mismatch_count,
    output int          pending_results
);
    import sti_pkg::*;

    typedef struct packed {
        status_t                status;
        logic                   found;
        logic [OUT_CNT_W-1:0]   entry_count;
    } table_reply_t;

    value_t       table_vals [CAPACITY];
    int           entry_total;
    int           fault_tally;
    table_reply_t expected_replies [$];

    // Apply one operation to the shadow table and return its reply.
    function automatic table_reply_t apply_table_op(logic [KIND_W-1:0] op, value_t operand);
        table_reply_t reply;
        int           pos;
        int           i;
        logic         present;
        pos = 0;
        while (pos < entry_total && table_vals[pos] < operand)
            pos++;
        present = (pos < entry_total) && (table_vals[pos] == operand);
        reply.status = STATUS_DONE;
        if (op == KIND_INSERT)
        begin
            if (entry_total >= CAPACITY)
                reply.status = STATUS_FULL;
            else
            begin
                for (i = entry_total; i > pos; i--)
                    table_vals[i] = table_vals[i-1];
                table_vals[pos] = operand;
                entry_total++;
            end
        end
        else if (op == KIND_DELETE)
        begin
            if (present)
            begin
                for (i = pos; i + 1 < entry_total; i++)
                    table_vals[i] = table_vals[i+1];
                entry_total--;
            end
            else
                reply.status = STATUS_ABSENT;
        end
        else if (!present)
            reply.status = STATUS_ABSENT;
        reply.found       = present;
        reply.entry_count = OUT_CNT_W'(entry_total);
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t want;
        if (!rst_n)
        begin
            entry_total = 0;
            fault_tally = 0;
            expected_replies.delete();
            mismatch_count  <= 0;
            pending_results <= 0;
        end
        else
        begin
            // Check the outgoing beat first: it can never belong to an
            // operation accepted on the same edge.
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    fault_tally++;
                    if (fault_tally <= 10)
                        $display("[%0t] unexpected result beat: status %0d found %0d count %0d",
                                 $realtime, m_tdata[1:0], m_tdata[2], m_tdata[9:3]);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (m_tdata[1:0] != want.status || m_tdata[2] != want.found ||
                        m_tdata[9:3] != want.entry_count || m_tdata[15:10] != '0)
                    begin
                        fault_tally++;
                        if (fault_tally <= 10)
                            $display({"[%0t] result mismatch: status %0d/%0d found %0d/%0d ",
                                      "count %0d/%0d pad %0d/0 (actual/expected)"},
                                     $realtime, m_tdata[1:0], want.status, m_tdata[2],
                                     want.found, m_tdata[9:3], want.entry_count,
                                     m_tdata[15:10]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_table_op(s_tuser, value_t'(s_tdata)));
            mismatch_count  <= fault_tally;
            pending_results <= expected_replies.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the sorted table insert/delete unit: clock, reset,
// operation stimulus, result back-pressure and the verdict.
// Depends on sti_pkg, sorted_table_insert_delete_unit and sti_result_checker.
module tb_top;
    import sti_pkg::*;

    // The unused kind code behaves as a find.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int TOTAL_OPS     = 1600;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] operand_value
    logic [1:0]  s_tuser  = '0;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [1:0] status, [2] found, [9:3] entry_count

    int     mismatch_count;
    int     pending_results;
    int     ops_sent;
    int     cycle_count;
    int     feed_mode = 1;
    int     sink_mode = 1;
    int     holds_wanted;
    value_t operand_pool [16];

    sorted_table_insert_delete_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sti_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length for one beat. Mode 0 gives back-to-back beats, mode 1
    // a uniform spread of gaps, mode 2 mostly none with odd gaps.
    function automatic int draw_gap(int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 16);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    endfunction

    // Skew the operation mix by phase: fill phases push the table to full
    // so rejected inserts occur, drain phases empty it again.
    function automatic logic [KIND_W-1:0] pick_kind(phase_t phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL:
                return (r < 80) ? KIND_INSERT : (r < 90) ? KIND_DELETE :
                       (r < 95) ? KIND_FIND : KIND_UNUSED;
            PH_DRAIN:
                return (r < 12) ? KIND_INSERT : (r < 85) ? KIND_DELETE :
                       (r < 95) ? KIND_FIND : KIND_UNUSED;
            default:
                return (r < 35) ? KIND_INSERT : (r < 70) ? KIND_DELETE :
                       (r < 93) ? KIND_FIND : KIND_UNUSED;
        endcase
    endfunction

    // Draw mostly from a small pool and a band around zero so that
    // duplicates, hits on delete and hits on find are common; the rest
    // are full-range values to toggle every operand bit.
    function automatic value_t pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return operand_pool[$urandom_range(0, 15)];
        if (r < 75)
            return value_t'(int'($urandom_range(0, 16)) - 8);
        return value_t'($urandom());
    endfunction

    // Offer one beat after the sender's idle gap and hold it until taken.
    // Valid stays high across back-to-back beats.
    task automatic push_op(input logic [KIND_W-1:0] kind, input value_t operand);
        int gap;
        gap = draw_gap(feed_mode);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= operand;
        do
            @(posedge clk);
        while (!s_tready);
        ops_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // Receiver: idle before each beat, or hold off for a long stretch
    // when the stimulus asks for one, then take the next result beat.
    initial
    begin
        int gap;
        int holds_served;
        holds_served = 0;
        wait (rst_n);
        forever
        begin
            if (holds_served < holds_wanted)
            begin
                holds_served++;
                gap = LONG_HOLD;
            end
            else
                gap = draw_gap(sink_mode);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Watchdog: end the run if it overruns the cycle budget.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** sorted_table_insert_delete_unit: FAILED **");
        $finish;
    end

    initial
    begin
        phase_t phase;
        int     phase_len;
        bit     first_phase;

        operand_pool[0] = 32'sh8000_0000;
        operand_pool[1] = 32'sh7fff_ffff;
        operand_pool[2] = 32'sd0;
        operand_pool[3] = -32'sd1;
        for (int i = 4; i < 16; i++)
            operand_pool[i] = value_t'($urandom());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, duplicates, unused kind, removal
        // at both ends, alternating bit patterns.
        push_op(KIND_FIND,   32'sd0);
        push_op(KIND_DELETE, 32'sd0);
        push_op(KIND_INSERT, 32'sh7fff_ffff);
        push_op(KIND_INSERT, 32'sh8000_0000);
        push_op(KIND_INSERT, 32'sd0);
        push_op(KIND_INSERT, -32'sd1);
        push_op(KIND_INSERT, 32'sd0);
        push_op(KIND_INSERT, 32'sd1);
        push_op(KIND_FIND,   32'sd0);
        push_op(KIND_UNUSED, 32'sh7fff_ffff);
        push_op(KIND_UNUSED, 32'sd5);
        push_op(KIND_DELETE, 32'sd0);
        push_op(KIND_FIND,   32'sd0);
        push_op(KIND_DELETE, 32'sd0);
        push_op(KIND_FIND,   32'sd0);
        push_op(KIND_DELETE, 32'sd0);
        push_op(KIND_DELETE, 32'sh8000_0000);
        push_op(KIND_DELETE, 32'sh7fff_ffff);
        push_op(KIND_INSERT, 32'sh5555_5555);
        push_op(KIND_INSERT, 32'shaaaa_aaaa);
        push_op(KIND_FIND,   32'shaaaa_aaaa);
        push_op(KIND_DELETE, -32'sd1);
        push_op(KIND_DELETE, 32'sd1);
        pause_until_drained();

        // Hold the receiver off for a long stretch while beats keep coming
        // back to back, so the unit fills up and drops s_tready.
        feed_mode = 0;
        holds_wanted++;
        repeat (40) push_op(pick_kind(PH_MIXED), pick_operand());
        pause_until_drained();

        // Random phases with their own idle patterns on both sides.
        first_phase = 1'b1;
        while (ops_sent < TOTAL_OPS)
        begin
            phase       = first_phase ? PH_FILL : phase_t'($urandom_range(0, 2));
            first_phase = 1'b0;
            feed_mode   = $urandom_range(0, 2);
            sink_mode   = $urandom_range(0, 2);
            phase_len   = (phase == PH_FILL) ? $urandom_range(100, 160)
                                             : $urandom_range(60, 140);
            repeat (phase_len) push_op(pick_kind(phase), pick_operand());
            if ($urandom_range(0, 2) == 0)
                pause_until_drained();
        end
        s_tvalid <= 1'b0;

        // Drain, then wait out a settling period so any stray beat can show up.
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results == 0)
            $display("** sorted_table_insert_delete_unit: PASSED **");
        else
            $display("** sorted_table_insert_delete_unit: FAILED **");
        $finish;
    end

endmodule
